@@ design/bsrc_pkg.sv @@
// Package: shared types, constants and status codes of the banker's algorithm engine.
package bsrc_pkg;
    localparam int MAX_PROCESSES = 16;
    localparam int MAX_RESOURCES = 5;
    localparam int COUNT_WIDTH = 8;
    localparam int PID_W = 4;
    localparam int ROW_W = MAX_RESOURCES * COUNT_WIDTH;
    localparam int SUM_W = COUNT_WIDTH + PID_W + 1;

    localparam logic [1:0] MODE_LOAD_MAX = 2'd0;
    localparam logic [1:0] MODE_LOAD_ALLOC = 2'd1;
    localparam logic [1:0] MODE_SAFETY = 2'd2;
    localparam logic [1:0] MODE_REQUEST = 2'd3;

    localparam logic [2:0] ST_LOADED = 3'd0;
    localparam logic [2:0] ST_SAFE = 3'd1;
    localparam logic [2:0] ST_UNSAFE = 3'd2;
    localparam logic [2:0] ST_REFUSED = 3'd3;
    localparam logic [2:0] ST_GRANTED = 3'd4;
    localparam logic [2:0] ST_DENIED = 3'd5;
    localparam logic [2:0] ST_BAD_ROW = 3'd6;

    localparam logic [2:0] CFG_PROCESS_COUNT = 3'd0;
    localparam logic [2:0] CFG_RESOURCE_COUNT = 3'd1;
    localparam logic [2:0] CFG_TOTAL_0 = 3'd2;
    localparam logic [2:0] CFG_TOTAL_4 = 3'd6;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef cnt_t [MAX_RESOURCES-1:0] row_t;

    // memory access from the sequencer
    typedef struct packed {
        logic rd_en;
        logic [PID_W-1:0] rd_addr;
        logic max_we;
        logic alloc_we;
        logic [PID_W-1:0] wr_addr;
        row_t wr_data;
    } mem_req_t;
endpackage

@@ design/bsrc_tables.sv @@
// Process table storage: max claim and allocation memories with valid bits.
module bsrc_tables (
    input  logic aclk,
    input  logic aresetn,
    input  bsrc_pkg::mem_req_t req,
    output bsrc_pkg::row_t max_rd,
    output bsrc_pkg::row_t alloc_rd
);
    bsrc_pkg::row_t max_mem [bsrc_pkg::MAX_PROCESSES];
    bsrc_pkg::row_t alloc_mem [bsrc_pkg::MAX_PROCESSES];
    bsrc_pkg::row_t max_q_reg, alloc_q_reg;
    logic [bsrc_pkg::MAX_PROCESSES-1:0] max_vld_reg, alloc_vld_reg;
    logic max_hit_reg, alloc_hit_reg;

    always_ff @(posedge aclk) begin
        if (req.max_we) max_mem[req.wr_addr] <= req.wr_data;
        if (req.alloc_we) alloc_mem[req.wr_addr] <= req.wr_data;
        if (req.rd_en) begin
            max_q_reg <= max_mem[req.rd_addr];
            alloc_q_reg <= alloc_mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_vld_reg <= '0;
            alloc_vld_reg <= '0;
            max_hit_reg <= 1'b0;
            alloc_hit_reg <= 1'b0;
        end else begin
            if (req.max_we) max_vld_reg[req.wr_addr] <= 1'b1;
            if (req.alloc_we) alloc_vld_reg[req.wr_addr] <= 1'b1;
            if (req.rd_en) begin
                max_hit_reg <= max_vld_reg[req.rd_addr];
                alloc_hit_reg <= alloc_vld_reg[req.rd_addr];
            end
        end
    end

    assign max_rd = max_hit_reg ? max_q_reg : '0;
    assign alloc_rd = alloc_hit_reg ? alloc_q_reg : '0;
endmodule

@@ design/bsrc_engine.sv @@
// Sequencer: available sum, row checks, request apply and cyclic safety scan.
module bsrc_engine (
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    output logic busy,
    input  logic [1:0] mode,
    input  logic [bsrc_pkg::PID_W-1:0] pid,
    input  bsrc_pkg::row_t amt,
    input  logic [bsrc_pkg::PID_W:0] np,
    input  logic [2:0] nr,
    input  bsrc_pkg::row_t totals,
    output bsrc_pkg::mem_req_t req,
    input  bsrc_pkg::row_t max_rd,
    input  bsrc_pkg::row_t alloc_rd,
    output logic done,
    output logic [2:0] res_status,
    output logic [63:0] res_seq,
    output logic [4:0] res_len
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SUM   = 7'b0000010,
        S_ROW   = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_UNDO  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    localparam int PW = bsrc_pkg::PID_W;
    localparam int NR = bsrc_pkg::MAX_RESOURCES;
    localparam int CW = bsrc_pkg::COUNT_WIDTH;
    localparam int SW = bsrc_pkg::SUM_W;

    state_t state_reg, state_next;
    logic [PW:0] cnt_reg, cnt_next;          // rows issued in sum pass
    logic [PW:0] rcv_reg, rcv_next;          // rows received
    logic [SW-1:0] sum_reg [NR];
    logic [SW-1:0] sum_next [NR];
    logic [SW-1:0] work_reg [NR];
    logic [SW-1:0] work_next [NR];
    logic [PW-1:0] idx_reg, idx_next;
    logic [PW:0] k_reg, k_next, fails_reg, fails_next;
    logic [bsrc_pkg::MAX_PROCESSES-1:0] fin_reg, fin_next;
    logic [63:0] seq_reg, seq_next;
    logic [2:0] status_reg, status_next;
    logic pend_reg, pend_next;               // row read in flight (sum pass or scan)
    bsrc_pkg::row_t saved_reg, saved_next;
    logic req_phase_reg, req_phase_next;     // scan belongs to a request

    logic [CW:0] avail [NR];
    logic [CW:0] need [NR];
    logic fits, bad, over;
    logic [PW-1:0] nxt_idx;
    logic [SW-1:0] tsum;

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign res_status = status_reg;
    assign res_seq = seq_reg;
    assign res_len = (status_reg == bsrc_pkg::ST_SAFE || status_reg == bsrc_pkg::ST_GRANTED)
                     ? k_reg : 5'd0;

    always_comb begin
        for (int r = 0; r < NR; r++) begin
            avail[r] = '0;
            if (r < nr) begin
                if ({{(SW-CW){1'b0}}, totals[r]} > sum_reg[r])
                    avail[r] = {1'b0, totals[r]} - sum_reg[r][CW:0];
            end
            need[r] = (max_rd[r] > alloc_rd[r]) ? {1'b0, max_rd[r] - alloc_rd[r]} : '0;
        end
        fits = 1'b1;
        bad = 1'b0;
        over = 1'b0;
        for (int r = 0; r < NR; r++) begin
            if (r < nr) begin
                if ({{(SW-CW-1){1'b0}}, need[r]} > work_reg[r]) fits = 1'b0;
                if (mode == bsrc_pkg::MODE_LOAD_MAX && amt[r] < alloc_rd[r]) bad = 1'b1;
                if (mode == bsrc_pkg::MODE_LOAD_ALLOC && amt[r] > max_rd[r]) bad = 1'b1;
                if ({1'b0, amt[r]} > avail[r]) over = 1'b1;
                if ({1'b0, alloc_rd[r]} + {1'b0, amt[r]} > {1'b0, max_rd[r]}) over = 1'b1;
            end
        end
        nxt_idx = ({1'b0, idx_reg} + 1'b1 >= np) ? '0 : idx_reg + 1'b1;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        rcv_next = rcv_reg;
        sum_next = sum_reg;
        work_next = work_reg;
        idx_next = idx_reg;
        k_next = k_reg;
        fails_next = fails_reg;
        fin_next = fin_reg;
        seq_next = seq_reg;
        status_next = status_reg;
        pend_next = 1'b0;
        saved_next = saved_reg;
        req_phase_next = req_phase_reg;
        req = '0;
        tsum = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_SUM;
                    cnt_next = '0;
                    rcv_next = '0;
                    for (int r = 0; r < NR; r++) sum_next[r] = '0;
                    req_phase_next = 1'b0;
                end
            end
            S_SUM: begin
                // stream rows, accumulate each row's allocations in the cycle after its read
                if (cnt_reg < np) begin
                    req.rd_en = 1'b1;
                    req.rd_addr = cnt_reg[PW-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end
                if (pend_reg) begin
                    for (int r = 0; r < NR; r++)
                        sum_next[r] = sum_reg[r] + {{(SW-CW){1'b0}}, alloc_rd[r]};
                    rcv_next = rcv_reg + 1'b1;
                end
                pend_next = (cnt_reg < np);
                if (pend_reg && rcv_reg + 1'b1 == np) begin
                    for (int r = 0; r < NR; r++) work_next[r] = '0;
                    if (mode == bsrc_pkg::MODE_SAFETY || req_phase_reg) begin
                        state_next = S_SCAN;
                        idx_next = '0;
                        k_next = '0;
                        fails_next = '0;
                        fin_next = '0;
                        seq_next = '0;
                    end else if ({1'b0, pid} >= np) begin
                        state_next = S_DONE;
                        status_next = bsrc_pkg::ST_BAD_ROW;
                        seq_next = '0;
                        k_next = '0;
                    end else begin
                        state_next = S_ROW;
                        req.rd_en = 1'b1;
                        req.rd_addr = pid;
                    end
                end
            end
            S_ROW: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                seq_next = '0;
                k_next = '0;
                state_next = S_DONE;
                req.wr_addr = pid;
                if (mode == bsrc_pkg::MODE_REQUEST) begin
                    if (over) begin
                        status_next = bsrc_pkg::ST_REFUSED;
                    end else begin
                        saved_next = alloc_rd;
                        req.alloc_we = 1'b1;
                        for (int r = 0; r < NR; r++)
                            req.wr_data[r] = (r < nr) ? alloc_rd[r] + amt[r] : alloc_rd[r];
                        req_phase_next = 1'b1;
                        state_next = S_SUM;
                        cnt_next = '0;
                        rcv_next = '0;
                        for (int r = 0; r < NR; r++) sum_next[r] = '0;
                    end
                end else if (bad) begin
                    status_next = bsrc_pkg::ST_BAD_ROW;
                end else begin
                    status_next = bsrc_pkg::ST_LOADED;
                    req.wr_data = amt;
                    req.max_we = (mode == bsrc_pkg::MODE_LOAD_MAX);
                    req.alloc_we = (mode == bsrc_pkg::MODE_LOAD_ALLOC);
                end
            end
            S_SCAN: begin
                if (k_reg == '0 && fails_reg == '0 && fin_reg == '0 && !pend_reg) begin
                    for (int r = 0; r < NR; r++)
                        work_next[r] = {{(SW-CW-1){1'b0}}, avail[r]};
                end
                if (!pend_reg) begin
                    // skip finished rows, else fetch the row under test
                    if (fin_reg[idx_reg]) begin
                        idx_next = nxt_idx;
                    end else begin
                        req.rd_en = 1'b1;
                        req.rd_addr = idx_reg;
                        pend_next = 1'b1;
                    end
                end else begin
                    if (fits) begin
                        fin_next[idx_reg] = 1'b1;
                        seq_next[4*k_reg[PW-1:0] +: PW] = idx_reg;
                        k_next = k_reg + 1'b1;
                        fails_next = '0;
                        for (int r = 0; r < NR; r++) begin
                            tsum = work_reg[r] + {{(SW-CW){1'b0}}, alloc_rd[r]};
                            if (r < nr) work_next[r] = tsum;
                        end
                    end else begin
                        fails_next = fails_reg + 1'b1;
                    end
                    idx_next = nxt_idx;
                    if (k_next == np) begin
                        state_next = S_DONE;
                        status_next = req_phase_reg ? bsrc_pkg::ST_GRANTED : bsrc_pkg::ST_SAFE;
                    end else if (fails_next >= np - k_next) begin
                        seq_next = '0;
                        k_next = '0;
                        if (req_phase_reg) begin
                            state_next = S_UNDO;
                        end else begin
                            state_next = S_DONE;
                            status_next = bsrc_pkg::ST_UNSAFE;
                        end
                    end
                end
            end
            S_UNDO: begin
                req.alloc_we = 1'b1;
                req.wr_addr = pid;
                req.wr_data = saved_reg;
                status_next = bsrc_pkg::ST_DENIED;
                state_next = S_DONE;
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pend_reg <= 1'b0;
            req_phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg <= pend_next;
            req_phase_reg <= req_phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rcv_reg <= rcv_next;
        sum_reg <= sum_next;
        work_reg <= work_next;
        idx_reg <= idx_next;
        k_reg <= k_next;
        fails_reg <= fails_next;
        fin_reg <= fin_next;
        seq_reg <= seq_next;
        status_reg <= status_next;
        saved_reg <= saved_next;
    end
endmodule

@@ design/bankers_safety_and_request_check_top.sv @@
// Top level: stream ports, configuration registers, table memories and sequencer.
//  channel | dir | tdata fields (low first)                       | tuser
//  s_      | in  | mode, process_id, amount_0..amount_4 (46 -> 48)| -
//  m_      | out | status, safe_sequence, sequence_length (72)    | -
//  cfg     | in  | cfg_we, cfg_index, cfg_wdata                   | -
// One item at a time. Every item first streams process_count rows from the
// allocation memory (one row a cycle) to rebuild available units; a safety scan
// then reads and tests each unfinished row, up to process_count squared visits.
// A request repeats the sum pass after its tentative write. Synchronous reset.
// s_tready drops while an item is in work or a result waits in the output register.
module bankers_safety_and_request_check_top (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [47:0] s_tdata,   // mode, process_id, amount_0..amount_4
    output logic m_tvalid,
    input  logic m_tready,
    output logic [71:0] m_tdata,   // status, safe_sequence, sequence_length
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_wdata
);
    logic [4:0] pc_reg;
    logic [2:0] rc_reg;
    bsrc_pkg::row_t totals_reg;
    logic [1:0] mode_reg;
    logic [3:0] pid_reg;
    bsrc_pkg::row_t amt_reg;
    logic out_vld_reg;
    logic [71:0] out_reg;
    logic busy, done, start;
    logic [2:0] st;
    logic [63:0] seq;
    logic [4:0] len;
    logic [4:0] np;
    logic [2:0] nr;
    bsrc_pkg::mem_req_t req;
    bsrc_pkg::row_t max_rd, alloc_rd;

    assign np = (pc_reg == 5'd0) ? 5'd1 : (pc_reg > 5'd16) ? 5'd16 : pc_reg;
    assign nr = (rc_reg == 3'd0) ? 3'd1 : (rc_reg > 3'd5) ? 3'd5 : rc_reg;
    assign s_tready = !busy && !out_vld_reg;
    assign start = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= 5'd1;
            rc_reg <= 3'd1;
            totals_reg <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    bsrc_pkg::CFG_PROCESS_COUNT: pc_reg <= cfg_wdata[4:0];
                    bsrc_pkg::CFG_RESOURCE_COUNT: rc_reg <= cfg_wdata[2:0];
                    default: begin
                        if (cfg_index >= bsrc_pkg::CFG_TOTAL_0
                                && cfg_index <= bsrc_pkg::CFG_TOTAL_4)
                            totals_reg[cfg_index - bsrc_pkg::CFG_TOTAL_0] <= cfg_wdata;
                    end
                endcase
            end
            if (done) out_vld_reg <= 1'b1;
            else if (m_tready) out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mode_reg <= s_tdata[1:0];
            pid_reg <= s_tdata[5:2];
            amt_reg <= s_tdata[45:6];
        end
        if (done) out_reg <= {len, seq, st};
    end

    bsrc_tables u_tables (
        .aclk(aclk), .aresetn(aresetn), .req(req), .max_rd(max_rd), .alloc_rd(alloc_rd)
    );

    bsrc_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .start(start), .busy(busy),
        .mode(start ? s_tdata[1:0] : mode_reg), .pid(pid_reg), .amt(amt_reg),
        .np(np), .nr(nr), .totals(totals_reg), .req(req),
        .max_rd(max_rd), .alloc_rd(alloc_rd), .done(done),
        .res_status(st), .res_seq(seq), .res_len(len)
    );
endmodule

@@ bench/tb.sv @@
// Self-checking bench for the banker's algorithm engine: table of directed items, then random.
`timescale 1ns / 100ps

module tb;
    import bsrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RAND_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 175;

    typedef struct packed {
        logic [1:0]       mode;
        logic [PID_W-1:0] pid;
        row_t             amt;
    } request_item_t;

    localparam int ITEM_W = $bits(request_item_t);

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] seq;
        logic [4:0]  len;
    } verdict_t;

    typedef struct packed {
        request_item_t item;
        logic          typed;
        verdict_t      verdict;
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [7:0]   cfg_wdata = '0;

    // mirror of the block's state and registers
    cnt_t         claim_mirror [MAX_PROCESSES][MAX_RESOURCES];
    cnt_t         alloc_mirror [MAX_PROCESSES][MAX_RESOURCES];
    logic [4:0]   proc_reg;
    logic [2:0]   res_reg;
    cnt_t         total_reg [MAX_RESOURCES];

    verdict_t     pending_verdicts [$];
    int           err_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_requests = 0;
    int           hold_served = 0;
    int           hold_left = 0;
    int           quiet_cycles = 0;

    bankers_safety_and_request_check_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int procs_in_use();
        if (proc_reg == 0) return 1;
        if (proc_reg > MAX_PROCESSES) return MAX_PROCESSES;
        return proc_reg;
    endfunction

    function automatic int res_in_use();
        if (res_reg == 0) return 1;
        if (res_reg > MAX_RESOURCES) return MAX_RESOURCES;
        return res_reg;
    endfunction

    function automatic int free_units(int r);
        int sum;
        sum = 0;
        if (r >= res_in_use()) return 0;
        for (int p = 0; p < procs_in_use(); p++) sum += alloc_mirror[p][r];
        return (total_reg[r] > sum) ? total_reg[r] - sum : 0;
    endfunction

    function automatic int need_units(int p, int r);
        return (claim_mirror[p][r] > alloc_mirror[p][r]) ?
               claim_mirror[p][r] - alloc_mirror[p][r] : 0;
    endfunction

    // cyclic scan from process 0; unsafe once every remaining process failed in a row
    function automatic bit scan_is_safe(output logic [63:0] seq, output logic [4:0] len);
        int work [MAX_RESOURCES];
        logic [MAX_PROCESSES-1:0] finished;
        int np, nr, i, k, fails;
        bit fits;
        np = procs_in_use();
        nr = res_in_use();
        finished = '0;
        i = 0; k = 0; fails = 0;
        seq = '0;
        len = '0;
        for (int r = 0; r < MAX_RESOURCES; r++) work[r] = free_units(r);
        forever begin
            if (finished[i]) begin
                i = (i + 1 >= np) ? 0 : i + 1;
                continue;
            end
            fits = 1'b1;
            for (int r = 0; r < nr; r++) if (need_units(i, r) > work[r]) fits = 1'b0;
            if (fits) begin
                finished[i] = 1'b1;
                seq[4*k +: 4] = i[3:0];
                k++;
                fails = 0;
                for (int r = 0; r < nr; r++) work[r] += alloc_mirror[i][r];
            end else begin
                fails++;
            end
            if (k == np) begin
                len = k[4:0];
                return 1'b1;
            end
            if (fails >= np - k) begin
                seq = '0;
                return 1'b0;
            end
            i = (i + 1 >= np) ? 0 : i + 1;
        end
    endfunction

    function automatic verdict_t predict_verdict(request_item_t it);
        verdict_t v;
        int np, nr, p;
        bit bad;
        cnt_t saved [MAX_RESOURCES];
        np = procs_in_use();
        nr = res_in_use();
        p = it.pid;
        v = '0;
        bad = 1'b0;
        if (it.mode == MODE_SAFETY) begin
            v.status = scan_is_safe(v.seq, v.len) ? ST_SAFE : ST_UNSAFE;
        end else if (p >= np) begin
            v.status = ST_BAD_ROW;
        end else if (it.mode == MODE_LOAD_MAX || it.mode == MODE_LOAD_ALLOC) begin
            for (int r = 0; r < nr; r++) begin
                if (it.mode == MODE_LOAD_MAX && it.amt[r] < alloc_mirror[p][r]) bad = 1'b1;
                if (it.mode == MODE_LOAD_ALLOC && it.amt[r] > claim_mirror[p][r]) bad = 1'b1;
            end
            if (bad) begin
                v.status = ST_BAD_ROW;
            end else begin
                for (int r = 0; r < MAX_RESOURCES; r++)
                    if (it.mode == MODE_LOAD_MAX) claim_mirror[p][r] = it.amt[r];
                    else alloc_mirror[p][r] = it.amt[r];
                v.status = ST_LOADED;
            end
        end else begin
            for (int r = 0; r < nr; r++) begin
                if (it.amt[r] > free_units(r)) bad = 1'b1;
                if (int'(alloc_mirror[p][r]) + int'(it.amt[r]) > claim_mirror[p][r]) bad = 1'b1;
            end
            if (bad) begin
                v.status = ST_REFUSED;
            end else begin
                for (int r = 0; r < nr; r++) begin
                    saved[r] = alloc_mirror[p][r];
                    alloc_mirror[p][r] = alloc_mirror[p][r] + it.amt[r];
                end
                if (scan_is_safe(v.seq, v.len)) begin
                    v.status = ST_GRANTED;
                end else begin
                    for (int r = 0; r < nr; r++) alloc_mirror[p][r] = saved[r];
                    v.status = ST_DENIED;
                end
            end
        end
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // result side: check, stall at random, long hold-off on request
    always @(posedge aclk) begin
        verdict_t want;
        if (m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected transfer", m_tdata[66:3], 64'd0);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[2:0] !== want.status)
                    report_mismatch("status", m_tdata[2:0], want.status);
                if (m_tdata[66:3] !== want.seq)
                    report_mismatch("safe_sequence", m_tdata[66:3], want.seq);
                if (m_tdata[71:67] !== want.len)
                    report_mismatch("sequence_length", m_tdata[71:67], want.len);
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_OFF_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** bankers_safety_and_request_check_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_PROCESS_COUNT:  proc_reg = val[4:0];
            CFG_RESOURCE_COUNT: res_reg = val[2:0];
            default:            total_reg[idx - CFG_TOTAL_0] = val;
        endcase
        @(posedge aclk);
    endtask

    task automatic configure(logic [4:0] pc, logic [2:0] rc, cnt_t tot [MAX_RESOURCES]);
        write_reg(CFG_PROCESS_COUNT, {3'b000, pc});
        write_reg(CFG_RESOURCE_COUNT, {5'b00000, rc});
        for (int r = 0; r < MAX_RESOURCES; r++) write_reg(CFG_TOTAL_0 + r[2:0], tot[r]);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // hold valid until the transfer; prediction happens at the accepting edge
    task automatic send_item(request_item_t it, logic typed, verdict_t typed_v);
        verdict_t v;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, it.amt, it.pid, it.mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        v = predict_verdict(it);
        pending_verdicts.push_back(typed ? typed_v : v);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic cnt_t pick_upto(int hi);
        if (hi <= 0) return '0;
        return ($urandom_range(0, 3) == 0) ? cnt_t'(hi) : cnt_t'($urandom_range(0, hi));
    endfunction

    function automatic request_item_t random_item();
        request_item_t it;
        int np, sel, need;
        np = procs_in_use();
        it.mode = MODE_LOAD_MAX;
        it.pid = '0;
        it.amt = '0;
        if ($urandom_range(0, 99) < 12) begin
            it = request_item_t'(ITEM_W'({$urandom, $urandom}));
            return it;
        end
        sel = $urandom_range(0, 99);
        it.mode = (sel < 18) ? MODE_LOAD_MAX : (sel < 38) ? MODE_LOAD_ALLOC :
                  (sel < 58) ? MODE_SAFETY : MODE_REQUEST;
        it.pid = ($urandom_range(0, 19) == 0) ? PID_W'($urandom_range(0, 15)) :
                 PID_W'($urandom_range(0, np - 1));
        for (int r = 0; r < MAX_RESOURCES; r++) begin
            case (it.mode)
                MODE_LOAD_MAX:
                    it.amt[r] = alloc_mirror[it.pid][r] +
                                pick_upto(($urandom_range(0, 1) ? 255 : 60) -
                                          alloc_mirror[it.pid][r] < 0 ? 0 :
                                          ($urandom_range(0, 1) ? 255 : 60) -
                                          alloc_mirror[it.pid][r]);
                MODE_LOAD_ALLOC:
                    it.amt[r] = pick_upto($urandom_range(0, 1) ? claim_mirror[it.pid][r] :
                                          claim_mirror[it.pid][r] / 4);
                default: begin
                    need = need_units(it.pid, r);
                    it.amt[r] = pick_upto($urandom_range(0, 1) ? need / 2 : need + 1);
                end
            endcase
        end
        return it;
    endfunction

    dir_row_t reset_rows [7];
    dir_row_t wide_rows [14];
    cnt_t     tot_v [MAX_RESOURCES];
    verdict_t no_verdict;

    initial begin
        no_verdict = '0;
        proc_reg = 5'd1;
        res_reg = 3'd1;
        for (int r = 0; r < MAX_RESOURCES; r++) total_reg[r] = '0;
        for (int p = 0; p < MAX_PROCESSES; p++)
            for (int r = 0; r < MAX_RESOURCES; r++) begin
                claim_mirror[p][r] = '0;
                alloc_mirror[p][r] = '0;
            end

        // reset settings: one process, one resource, no units
        reset_rows = '{
            '{'{MODE_SAFETY, 4'd9, '0}, 1'b1, '{ST_SAFE, 64'd0, 5'd1}},
            '{'{MODE_LOAD_MAX, 4'd1, '1}, 1'b1, '{ST_BAD_ROW, 64'd0, 5'd0}},
            '{'{MODE_REQUEST, 4'd0, {8'd0, 8'd0, 8'd0, 8'd0, 8'd1}}, 1'b1,
              '{ST_REFUSED, 64'd0, 5'd0}},
            '{'{MODE_LOAD_ALLOC, 4'd0, {8'd0, 8'd0, 8'd0, 8'd0, 8'd5}}, 1'b1,
              '{ST_BAD_ROW, 64'd0, 5'd0}},
            '{'{MODE_LOAD_MAX, 4'd0, {8'd0, 8'd0, 8'd0, 8'd0, 8'd10}}, 1'b1,
              '{ST_LOADED, 64'd0, 5'd0}},
            // unused columns stored beyond the claim: their need clamps to zero later
            '{'{MODE_LOAD_ALLOC, 4'd0, {8'd7, 8'd7, 8'd7, 8'd200, 8'd3}}, 1'b1,
              '{ST_LOADED, 64'd0, 5'd0}},
            '{'{MODE_REQUEST, 4'd15, '1}, 1'b1, '{ST_BAD_ROW, 64'd0, 5'd0}}
        };
        wide_rows = '{
            '{'{MODE_SAFETY, 4'd0, '0}, 1'b0, '0},
            '{'{MODE_LOAD_MAX, 4'd15, '1}, 1'b0, '0},
            '{'{MODE_LOAD_ALLOC, 4'd15, '1}, 1'b0, '0},
            '{'{MODE_SAFETY, 4'd3, '0}, 1'b0, '0},
            '{'{MODE_LOAD_MAX, 4'd15, '0}, 1'b0, '0},
            '{'{MODE_LOAD_ALLOC, 4'd15, '0}, 1'b0, '0},
            '{'{MODE_LOAD_MAX, 4'd1, {8'd40, 8'd40, 8'd40, 8'd40, 8'd40}}, 1'b0, '0},
            '{'{MODE_LOAD_MAX, 4'd2, {8'd250, 8'd250, 8'd250, 8'd250, 8'd250}}, 1'b0, '0},
            '{'{MODE_LOAD_ALLOC, 4'd1, {8'd20, 8'd20, 8'd20, 8'd20, 8'd20}}, 1'b0, '0},
            '{'{MODE_REQUEST, 4'd2, {8'd200, 8'd200, 8'd200, 8'd200, 8'd200}}, 1'b0, '0},
            '{'{MODE_REQUEST, 4'd1, {8'd20, 8'd20, 8'd20, 8'd20, 8'd20}}, 1'b0, '0},
            '{'{MODE_REQUEST, 4'd1, {8'd1, 8'd0, 8'd0, 8'd0, 8'd0}}, 1'b0, '0},
            '{'{MODE_REQUEST, 4'd2, {8'd5, 8'd5, 8'd5, 8'd5, 8'd5}}, 1'b0, '0},
            '{'{MODE_SAFETY, 4'd0, '0}, 1'b0, '0}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (reset_rows[i]) send_item(reset_rows[i].item, 1'b1, reset_rows[i].verdict);
        drain();
        for (int r = 0; r < MAX_RESOURCES; r++) tot_v[r] = 8'd255;
        configure(5'd16, 3'd5, tot_v);
        foreach (wide_rows[i]) send_item(wide_rows[i].item, 1'b0, no_verdict);
        drain();
        // counts beyond range and no units at all: overcommitted totals
        for (int r = 0; r < MAX_RESOURCES; r++) tot_v[r] = 8'd0;
        configure(5'd31, 3'd7, tot_v);
        send_item('{MODE_SAFETY, 4'd0, '0}, 1'b0, no_verdict);
        send_item('{MODE_REQUEST, 4'd1, '0}, 1'b0, no_verdict);
        drain();
        configure(5'd0, 3'd0, tot_v);
        send_item('{MODE_SAFETY, 4'd0, '0}, 1'b0, no_verdict);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            for (int r = 0; r < MAX_RESOURCES; r++)
                case ($urandom_range(0, 3))
                    0: tot_v[r] = 8'd255;
                    1: tot_v[r] = 8'd0;
                    default: tot_v[r] = cnt_t'($urandom_range(30, 255));
                endcase
            case ($urandom_range(0, 5))
                0: configure(5'd16, 3'($urandom_range(0, 7)), tot_v);
                1: configure(5'($urandom_range(17, 31)), 3'($urandom_range(0, 7)), tot_v);
                2: configure(5'd1, 3'($urandom_range(0, 7)), tot_v);
                default: configure(5'($urandom_range(0, 8)), 3'($urandom_range(1, 5)), tot_v);
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 0 && n == 20) hold_requests++;
                send_item(random_item(), 1'b0, no_verdict);
            end
            drain();
        end

        repeat (50) @(posedge aclk);
        if (err_count == 0) begin
            $display("** bankers_safety_and_request_check_top: PASSED **");
        end else begin
            $display("** bankers_safety_and_request_check_top: FAILED **");
        end
        $finish;
    end
endmodule
